/* rtl/tms_pkg.sv */
// ---------------------------------------------------------------------------
// Transform matrix stack package
// Shared types, constants and table functions for the matrix stack block.
// ---------------------------------------------------------------------------
package tms_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int LVL_W       = $clog2(STACK_DEPTH);
  localparam int ADDR_W      = LVL_W + 4;
  localparam int MEM_DEPTH   = STACK_DEPTH * 16;

  localparam logic signed [31:0] Q_ONE       = 32'sd65536;
  localparam logic signed [31:0] ANG_TWO_PI  = 32'sd411775;
  localparam logic signed [31:0] ANG_PI      = 32'sd205887;
  localparam logic signed [31:0] ANG_HALF_PI = 32'sd102944;
  localparam logic signed [31:0] CORDIC_GAIN = 32'sd39797;

  localparam logic [2:0] MODE_PUSH      = 3'd0;
  localparam logic [2:0] MODE_POP       = 3'd1;
  localparam logic [2:0] MODE_TRANSLATE = 3'd2;
  localparam logic [2:0] MODE_ROTATE    = 3'd3;
  localparam logic [2:0] MODE_SCALE     = 3'd4;
  localparam logic [2:0] MODE_POINT     = 3'd5;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;
  localparam logic [1:0] ST_BAD_AXIS  = 2'd3;

  localparam logic [1:0] AXIS_BAD = 2'd3;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [31:0] x_val;
    logic signed [31:0] y_val;
    logic signed [31:0] z_val;
    logic [1:0]         axis;
    logic signed [31:0] angle;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic [1:0]         status;
    logic [4:0]         level;
  } res_t;

  // Control that travels beside the operands into the multiply unit.
  typedef struct packed {
    logic       vld;
    logic       first;
    logic       last;
    logic [1:0] tag;
  } mac_ctl_t;

  function automatic logic signed [31:0] atan_q16(input logic [3:0] i);
    logic signed [31:0] v;
    case (i)
      4'd0:    v = 32'sd51472;
      4'd1:    v = 32'sd30386;
      4'd2:    v = 32'sd16055;
      4'd3:    v = 32'sd8150;
      4'd4:    v = 32'sd4091;
      4'd5:    v = 32'sd2047;
      4'd6:    v = 32'sd1024;
      4'd7:    v = 32'sd512;
      4'd8:    v = 32'sd256;
      4'd9:    v = 32'sd128;
      4'd10:   v = 32'sd64;
      4'd11:   v = 32'sd32;
      4'd12:   v = 32'sd16;
      4'd13:   v = 32'sd8;
      4'd14:   v = 32'sd4;
      4'd15:   v = 32'sd2;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

  // Identity matrix entry; entry k is row k[1:0], column k[3:2].
  function automatic logic signed [31:0] unit_entry(input logic [3:0] k);
    return (k[1:0] == k[3:2]) ? Q_ONE : 32'sd0;
  endfunction

  // Slots of the rotation matrix: cosine, cosine, minus sine, sine.
  function automatic logic [3:0] rot_slot(input logic [1:0] axis, input logic [1:0] j);
    logic [3:0] s;
    case ({axis, j})
      4'b00_00: s = 4'd5;
      4'b00_01: s = 4'd10;
      4'b00_10: s = 4'd6;
      4'b00_11: s = 4'd9;
      4'b01_00: s = 4'd0;
      4'b01_01: s = 4'd10;
      4'b01_10: s = 4'd8;
      4'b01_11: s = 4'd2;
      4'b10_00: s = 4'd0;
      4'b10_01: s = 4'd5;
      4'b10_10: s = 4'd1;
      4'b10_11: s = 4'd4;
      default:  s = 4'd15;
    endcase
    return s;
  endfunction

  // Entry idx of the elementary matrix of a translate, scale or rotate command.
  function automatic logic signed [31:0] elem(input cmd_t c, input logic [3:0] idx,
                                              input logic signed [31:0] cs,
                                              input logic signed [31:0] sn);
    logic signed [31:0] v;
    v = unit_entry(idx);
    case (c.mode)
      MODE_TRANSLATE: begin
        if (idx == 4'd12) v = c.x_val;
        if (idx == 4'd13) v = c.y_val;
        if (idx == 4'd14) v = c.z_val;
      end
      MODE_SCALE: begin
        if (idx == 4'd0)  v = c.x_val;
        if (idx == 4'd5)  v = c.y_val;
        if (idx == 4'd10) v = c.z_val;
      end
      MODE_ROTATE: begin
        if (idx == rot_slot(c.axis, 2'd0)) v = cs;
        if (idx == rot_slot(c.axis, 2'd1)) v = cs;
        if (idx == rot_slot(c.axis, 2'd2)) v = -sn;
        if (idx == rot_slot(c.axis, 2'd3)) v = sn;
      end
      default: v = unit_entry(idx);
    endcase
    return v;
  endfunction

endpackage

/* rtl/transform_matrix_stack_top.sv */
// ---------------------------------------------------------------------------
// Transform matrix stack
// Stack of 4x4 Q16.16 matrices in one memory, updated through a shared
// multiply-accumulate unit under a small sequencer.
// ---------------------------------------------------------------------------
// For a matrix command each of the four rows takes 4 memory reads and 16
// multiplies through the single multiplier; a point transform works three
// rows with 4 multiplies each. One command is in work at a time.
// Reset empties the stack to the identity matrix at level zero at once; the
// other levels hold nothing until a push writes them.
module transform_matrix_stack_top import tms_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  cmd_t in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output res_t out_data_o
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_CORDIC = 6'b000010,
    S_COPY   = 6'b000100,
    S_LOAD   = 6'b001000,
    S_MAC    = 6'b010000,
    S_DONE   = 6'b100000
  } state_e;

  state_e             state_q, state_d;
  cmd_t               cmd_q;
  logic [LVL_W-1:0]   lvl_q;
  logic [1:0]         status_q;
  logic [4:0]         cnt_q;
  logic [1:0]         row_q;
  logic signed [31:0] rowreg_q [4];
  logic signed [31:0] pt_q [3];
  res_t               out_q;
  logic               out_valid_q;
  logic [15:0]        v0_q;

  logic [31:0]        mem [MEM_DEPTH];
  logic [31:0]        mem_q;
  logic [3:0]         rd_k, rd_k_q;
  logic               rd_ident_q;
  logic signed [31:0] rdata;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic [31:0]        wr_data;

  logic               accept, point, can_out, cstart, cdone;
  logic [4:0]         nmul;
  logic signed [31:0] cs, sn, mac_b;
  mac_ctl_t           mac_ctl;
  logic               mac_vld;
  logic [1:0]         mac_tag;
  logic signed [31:0] mac_res;

  assign accept  = in_valid_i && (state_q == S_IDLE);
  assign point   = (cmd_q.mode == MODE_POINT);
  assign nmul    = point ? 5'd4 : 5'd16;
  assign can_out = !out_valid_q || !out_stall_i;
  assign cstart  = accept && (in_data_i.mode == MODE_ROTATE) && (in_data_i.axis != AXIS_BAD);

  tms_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cstart),
    .angle_i (in_data_i.angle),
    .done_o  (cdone),
    .cos_o   (cs),
    .sin_o   (sn)
  );

  // Row r of the top matrix is read as entries r, r+4, r+8, r+12.
  always_comb begin
    case (state_q)
      S_COPY:  rd_k = cnt_q[3:0];
      S_LOAD:  rd_k = {cnt_q[1:0], row_q};
      default: rd_k = 4'd0;
    endcase
  end

  // Level zero entries never written since reset read as identity.
  assign rdata = rd_ident_q ? unit_entry(rd_k_q) : mem_q;

  always_comb begin
    mac_ctl.vld   = (state_q == S_MAC) && (cnt_q < nmul);
    mac_ctl.first = (cnt_q[1:0] == 2'd0);
    mac_ctl.last  = (cnt_q[1:0] == 2'd3);
    mac_ctl.tag   = cnt_q[3:2];
    if (point) begin
      case (cnt_q[1:0])
        2'd0:    mac_b = cmd_q.x_val;
        2'd1:    mac_b = cmd_q.y_val;
        2'd2:    mac_b = cmd_q.z_val;
        default: mac_b = Q_ONE;
      endcase
    end else begin
      mac_b = elem(cmd_q, {cnt_q[3:2], cnt_q[1:0]}, cs, sn);
    end
  end

  tms_mac u_mac (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (mac_ctl),
    .a_i       (rowreg_q[cnt_q[1:0]]),
    .b_i       (mac_b),
    .res_vld_o (mac_vld),
    .res_tag_o (mac_tag),
    .res_o     (mac_res)
  );

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = {lvl_q, mac_tag, row_q};
    wr_data = mac_res;
    if ((state_q == S_COPY) && (cnt_q != 5'd0)) begin
      wr_en   = 1'b1;
      wr_addr = {lvl_q + LVL_W'(1), cnt_q[3:0] - 4'd1};
      wr_data = rdata;
    end else if (mac_vld && !point) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    mem_q      <= mem[{lvl_q, rd_k}];
    rd_k_q     <= rd_k;
    rd_ident_q <= (lvl_q == '0) && !v0_q[rd_k];
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (in_data_i.mode)
            MODE_PUSH:
              state_d = (lvl_q == LVL_W'(STACK_DEPTH - 1)) ? S_DONE : S_COPY;
            MODE_TRANSLATE, MODE_SCALE, MODE_POINT:
              state_d = S_LOAD;
            MODE_ROTATE:
              state_d = (in_data_i.axis == AXIS_BAD) ? S_DONE : S_CORDIC;
            default:
              state_d = S_DONE;
          endcase
        end
      end
      S_CORDIC: if (cdone) state_d = S_LOAD;
      S_COPY:   if (cnt_q == 5'd16) state_d = S_DONE;
      S_LOAD:   if (cnt_q == 5'd4) state_d = S_MAC;
      S_MAC: begin
        if (cnt_q == nmul + 5'd1) begin
          if ((point && row_q == 2'd2) || row_q == 2'd3) state_d = S_DONE;
          else                                           state_d = S_LOAD;
        end
      end
      S_DONE:   if (can_out) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      lvl_q       <= '0;
      out_valid_q <= 1'b0;
      v0_q        <= '0;
    end else begin
      state_q <= state_d;
      if (wr_en && (wr_addr[ADDR_W-1:4] == '0)) v0_q[wr_addr[3:0]] <= 1'b1;
      if (accept && (in_data_i.mode == MODE_POP) && (lvl_q != '0)) lvl_q <= lvl_q - LVL_W'(1);
      if ((state_q == S_COPY) && (cnt_q == 5'd16)) lvl_q <= lvl_q + LVL_W'(1);
      if ((state_q == S_DONE) && can_out) out_valid_q <= 1'b1;
      else if (!out_stall_i)              out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q    <= in_data_i;
      cnt_q    <= 5'd0;
      row_q    <= 2'd0;
      pt_q[0]  <= 32'sd0;
      pt_q[1]  <= 32'sd0;
      pt_q[2]  <= 32'sd0;
      case (in_data_i.mode)
        MODE_PUSH:
          status_q <= (lvl_q == LVL_W'(STACK_DEPTH - 1)) ? ST_OVERFLOW : ST_OK;
        MODE_POP:
          status_q <= (lvl_q == '0) ? ST_UNDERFLOW : ST_OK;
        MODE_ROTATE:
          status_q <= (in_data_i.axis == AXIS_BAD) ? ST_BAD_AXIS : ST_OK;
        default:
          status_q <= ST_OK;
      endcase
    end
    case (state_q)
      S_COPY: cnt_q <= cnt_q + 5'd1;
      S_LOAD: begin
        if (cnt_q != 5'd0) rowreg_q[cnt_q[1:0] - 2'd1] <= rdata;
        cnt_q <= (cnt_q == 5'd4) ? 5'd0 : cnt_q + 5'd1;
      end
      S_MAC: begin
        if (cnt_q == nmul + 5'd1) begin
          cnt_q <= 5'd0;
          row_q <= row_q + 2'd1;
        end else begin
          cnt_q <= cnt_q + 5'd1;
        end
      end
      default: ;
    endcase
    if (mac_vld && point && (row_q != 2'd3)) pt_q[row_q] <= mac_res;
    if ((state_q == S_DONE) && can_out) begin
      out_q.out_x  <= pt_q[0];
      out_q.out_y  <= pt_q[1];
      out_q.out_z  <= pt_q[2];
      out_q.status <= status_q;
      out_q.level  <= 5'(lvl_q);
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* rtl/tms_mac.sv */
// ---------------------------------------------------------------------------
// Matrix stack multiply-accumulate unit
// One signed 32x32 multiplier, a rounding stage and a saturating accumulator.
// ---------------------------------------------------------------------------
module tms_mac import tms_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mac_ctl_t           ctl_i,
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] b_i,
  output logic               res_vld_o,
  output logic [1:0]         res_tag_o,
  output logic signed [31:0] res_o
);

  logic signed [63:0] prod_q;
  mac_ctl_t           ctl_q;
  logic signed [49:0] acc_q, acc_d;
  logic signed [63:0] prod_rnd;
  logic signed [47:0] rnd;
  logic               res_vld_q;
  logic [1:0]         res_tag_q;
  logic signed [31:0] res_q;

  // Product rounded to Q16.16: add one half and shift right with floor.
  assign prod_rnd = prod_q + 64'sd32768;
  assign rnd      = prod_rnd[63:16];
  assign acc_d    = (ctl_q.first ? 50'sd0 : acc_q) + 50'(rnd);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q     <= '0;
      res_vld_q <= 1'b0;
    end else begin
      ctl_q     <= ctl_i;
      res_vld_q <= ctl_q.vld && ctl_q.last;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
    if (ctl_q.vld) begin
      acc_q     <= acc_d;
      res_tag_q <= ctl_q.tag;
      if (acc_d > 50'sd2147483647)       res_q <= 32'sh7fffffff;
      else if (acc_d < -50'sd2147483648) res_q <= 32'sh80000000;
      else                               res_q <= acc_d[31:0];
    end
  end

  assign res_vld_o = res_vld_q;
  assign res_tag_o = res_tag_q;
  assign res_o     = res_q;

endmodule

/* rtl/tms_cordic.sv */
// ---------------------------------------------------------------------------
// Matrix stack sine and cosine unit
// Reduces the angle modulo two pi by conditional subtraction, folds it into
// the right half plane and runs sixteen CORDIC rotations.
// ---------------------------------------------------------------------------
module tms_cordic import tms_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [31:0] angle_i,
  output logic               done_o,
  output logic signed [31:0] cos_o,
  output logic signed [31:0] sin_o
);

  typedef enum logic [3:0] {
    C_IDLE = 4'b0001,
    C_RED  = 4'b0010,
    C_FOLD = 4'b0100,
    C_ITER = 4'b1000
  } cstate_e;

  cstate_e            state_q, state_d;
  logic [3:0]         cnt_q;
  logic [31:0]        mag_q;
  logic               neg_q, flip_q, done_q;
  logic signed [31:0] x_q, y_q, z_q, cos_q, sin_q;
  logic [32:0]        red_sub;
  logic signed [31:0] r0, r1, r2;
  logic               fl;
  logic signed [31:0] xs, ys, nx, ny, nz;

  assign red_sub = {1'b0, mag_q} - (33'(ANG_TWO_PI) << cnt_q);

  always_comb begin
    r0 = (neg_q && (mag_q != 32'd0)) ? ANG_TWO_PI - $signed(mag_q) : $signed(mag_q);
    r1 = (r0 > ANG_PI) ? r0 - ANG_TWO_PI : r0;
    fl = 1'b0;
    r2 = r1;
    if (r1 > ANG_HALF_PI) begin
      r2 = r1 - ANG_PI;
      fl = 1'b1;
    end else if (r1 < -ANG_HALF_PI) begin
      r2 = r1 + ANG_PI;
      fl = 1'b1;
    end
  end

  assign xs = x_q >>> cnt_q;
  assign ys = y_q >>> cnt_q;
  assign nx = (z_q >= 0) ? x_q - ys : x_q + ys;
  assign ny = (z_q >= 0) ? y_q + xs : y_q - xs;
  assign nz = (z_q >= 0) ? z_q - atan_q16(cnt_q) : z_q + atan_q16(cnt_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      C_IDLE:  if (start_i) state_d = C_RED;
      C_RED:   if (cnt_q == 4'd0) state_d = C_FOLD;
      C_FOLD:  state_d = C_ITER;
      C_ITER:  if (cnt_q == 4'd15) state_d = C_IDLE;
      default: state_d = C_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == C_ITER) && (cnt_q == 4'd15);
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      C_IDLE: begin
        neg_q <= angle_i[31];
        mag_q <= angle_i[31] ? 32'(-angle_i) : angle_i;
        // 411775 shifted by 13 is its largest power-of-two multiple below two to the 32.
        cnt_q <= 4'd13;
      end
      C_RED: begin
        if (!red_sub[32]) mag_q <= red_sub[31:0];
        cnt_q <= cnt_q - 4'd1;
      end
      C_FOLD: begin
        x_q    <= CORDIC_GAIN;
        y_q    <= 32'sd0;
        z_q    <= r2;
        flip_q <= fl;
        cnt_q  <= 4'd0;
      end
      C_ITER: begin
        x_q   <= nx;
        y_q   <= ny;
        z_q   <= nz;
        cnt_q <= cnt_q + 4'd1;
        if (cnt_q == 4'd15) begin
          cos_q <= flip_q ? -nx : nx;
          sin_q <= flip_q ? -ny : ny;
        end
      end
      default: cnt_q <= 4'd0;
    endcase
  end

  assign done_o = done_q;
  assign cos_o  = cos_q;
  assign sin_o  = sin_q;

endmodule

/* tb/transform_matrix_stack_checker.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Matrix stack result checker
// Watches both channels of the matrix stack and keeps its own copy of the
// stack. On each accepted command it works out the expected result. Each
// result that leaves the block is compared field by field with the oldest
// one still waiting.
// ---------------------------------------------------------------------------
module transform_matrix_stack_checker import tms_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_stall_i,
  input  cmd_t in_data_i,
  input  logic out_valid_i,
  input  logic out_stall_i,
  input  res_t out_data_i,
  output int   fail_count_o,
  output int   pending_o
);

  logic signed [31:0] stack_mem [STACK_DEPTH][16];
  int unsigned        top_lvl;
  res_t               expected_q[$];

  assign pending_o = expected_q.size();

  function automatic longint rnd_prod(longint a, longint b);
    return (a * b + 32768) >>> 16;
  endfunction

  function automatic logic signed [31:0] sat32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic void sin_cos(input logic signed [31:0] ang,
                                  output logic signed [31:0] cs,
                                  output logic signed [31:0] sn);
    longint r, x, y, nx;
    bit flip;
    r = longint'(ang) % longint'(ANG_TWO_PI);
    x = CORDIC_GAIN;
    y = 0;
    flip = 0;
    if (r < 0) r += ANG_TWO_PI;
    if (r > ANG_PI) r -= ANG_TWO_PI;
    if (r > ANG_HALF_PI) begin
      r -= ANG_PI;
      flip = 1;
    end else if (r < -longint'(ANG_HALF_PI)) begin
      r += ANG_PI;
      flip = 1;
    end
    for (int i = 0; i < 16; i++) begin
      if (r >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        r -= atan_q16(4'(i));
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        r += atan_q16(4'(i));
      end
      x = nx;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    cs = x[31:0];
    sn = y[31:0];
  endfunction

  // Top matrix is replaced by top * e.
  task automatic post_mul(input logic signed [31:0] e [16]);
    logic signed [31:0] prod [16];
    longint acc;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        acc = 0;
        for (int k = 0; k < 4; k++)
          acc += rnd_prod(stack_mem[top_lvl][r + 4*k], e[k + 4*c]);
        prod[4*c + r] = sat32(acc);
      end
    end
    stack_mem[top_lvl] = prod;
  endtask

  task automatic predict_command(input cmd_t cmd);
    res_t res;
    logic signed [31:0] e [16];
    logic signed [31:0] cs, sn;
    longint acc;
    logic signed [31:0] pt [3];
    res = '0;
    for (int k = 0; k < 16; k++) e[k] = (k % 5 == 0) ? Q_ONE : 32'sd0;
    case (cmd.mode)
      MODE_PUSH: begin
        if (top_lvl + 1 >= STACK_DEPTH) res.status = ST_OVERFLOW;
        else begin
          stack_mem[top_lvl + 1] = stack_mem[top_lvl];
          top_lvl++;
        end
      end
      MODE_POP: begin
        if (top_lvl == 0) res.status = ST_UNDERFLOW;
        else top_lvl--;
      end
      MODE_TRANSLATE: begin
        e[12] = cmd.x_val;
        e[13] = cmd.y_val;
        e[14] = cmd.z_val;
        post_mul(e);
      end
      MODE_ROTATE: begin
        if (cmd.axis == AXIS_BAD) res.status = ST_BAD_AXIS;
        else begin
          sin_cos(cmd.angle, cs, sn);
          e[rot_slot(cmd.axis, 2'd0)] = cs;
          e[rot_slot(cmd.axis, 2'd1)] = cs;
          e[rot_slot(cmd.axis, 2'd2)] = -sn;
          e[rot_slot(cmd.axis, 2'd3)] = sn;
          post_mul(e);
        end
      end
      MODE_SCALE: begin
        e[0]  = cmd.x_val;
        e[5]  = cmd.y_val;
        e[10] = cmd.z_val;
        post_mul(e);
      end
      MODE_POINT: begin
        for (int r = 0; r < 3; r++) begin
          acc = rnd_prod(cmd.x_val, stack_mem[top_lvl][r])
              + rnd_prod(cmd.y_val, stack_mem[top_lvl][4 + r])
              + rnd_prod(cmd.z_val, stack_mem[top_lvl][8 + r])
              + longint'(stack_mem[top_lvl][12 + r]);
          pt[r] = sat32(acc);
        end
        res.out_x = pt[0];
        res.out_y = pt[1];
        res.out_z = pt[2];
      end
      default: ;
    endcase
    res.level = top_lvl[4:0];
    expected_q.push_back(res);
  endtask

  task automatic report(input string name, input longint exp_v, input longint act_v);
    $display("%0t: mismatch on %s: expected %0d, actual %0d", $time, name, exp_v, act_v);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      for (int l = 0; l < STACK_DEPTH; l++)
        for (int k = 0; k < 16; k++) stack_mem[l][k] = '0;
      for (int k = 0; k < 16; k++) stack_mem[0][k] = (k % 5 == 0) ? Q_ONE : 32'sd0;
      top_lvl = 0;
      expected_q.delete();
      fail_count_o = 0;
    end else begin
      if (in_valid_i && !in_stall_i) predict_command(in_data_i);
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result transfer with nothing expected, actual %p",
                   $time, out_data_i);
          fail_count_o++;
        end else begin
          want = expected_q.pop_front();
          if (out_data_i.out_x !== want.out_x) report("out_x", want.out_x, out_data_i.out_x);
          if (out_data_i.out_y !== want.out_y) report("out_y", want.out_y, out_data_i.out_y);
          if (out_data_i.out_z !== want.out_z) report("out_z", want.out_z, out_data_i.out_z);
          if (out_data_i.status !== want.status)
            report("status", want.status, out_data_i.status);
          if (out_data_i.level !== want.level) report("level", want.level, out_data_i.level);
        end
      end
    end
  end

endmodule

/* tb/transform_matrix_stack_top_tb.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Matrix stack testbench
// Drives directed and random command sequences with random gaps and
// result stalls, and reports the verdict from the checker's failure count.
// ---------------------------------------------------------------------------
module transform_matrix_stack_top_tb;
  import tms_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  cmd_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  res_t out_data;
  int   fail_count;
  int   pending;
  int   idle_cycles = 0;
  bit   stall_on = 1'b1;

  always #10 clk_i = ~clk_i;

  transform_matrix_stack_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data)
  );

  transform_matrix_stack_checker checker_i (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_data_i(out_data),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
    return $urandom_range(0, 3);
  endfunction

  // Receiver stalls in bursts; some stretches have none at all.
  always @(posedge clk_i) begin
    if ($urandom_range(0, 199) == 0) stall_on <= ~stall_on;
    if (!stall_on) out_stall <= 1'b0;
    else if ($urandom_range(0, 29) == 0) out_stall <= 1'b1;
    else if ($urandom_range(0, 3) == 0) out_stall <= 1'b0;
  end

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic signed [31:0] rand_q();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'sh7fffffff;
      2: return 32'sh80000000;
      3: return $signed($urandom_range(0, 262143)) - 32'sd131072;
      default: return $signed($urandom_range(0, 8191)) - 32'sd4096 + Q_ONE;
    endcase
  endfunction

  // Valid drops only when a gap follows, so back-to-back transfers keep it high.
  task automatic send(input logic [2:0] mode, input logic signed [31:0] x,
                      input logic signed [31:0] y, input logic signed [31:0] z,
                      input logic [1:0] axis, input logic signed [31:0] ang);
    int gap;
    gap = gap_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= '{mode: mode, x_val: x, y_val: y, z_val: z, axis: axis, angle: ang};
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  task automatic send_random(input int depth);
    int sel;
    logic [2:0] mode;
    sel = $urandom_range(0, 99);
    // Keep the stack mostly shallow, with occasional deep climbs.
    if (sel < 14) mode = (depth > 5 && $urandom_range(0, 3) != 0) ? MODE_POP : MODE_PUSH;
    else if (sel < 24) mode = MODE_POP;
    else if (sel < 40) mode = MODE_TRANSLATE;
    else if (sel < 58) mode = MODE_ROTATE;
    else if (sel < 72) mode = MODE_SCALE;
    else if (sel < 97) mode = MODE_POINT;
    else mode = 3'($urandom_range(6, 7));
    send(mode, rand_q(), rand_q(), rand_q(),
         ($urandom_range(0, 9) == 0) ? AXIS_BAD : 2'($urandom_range(0, 2)),
         ($urandom_range(0, 3) == 0) ? 32'($urandom) : rand_q());
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: underflow, each mode, extremes, bad axis, unused modes.
    send(MODE_POP, 0, 0, 0, 0, 0);
    send(MODE_POINT, 32'sh7fffffff, 32'sh80000000, Q_ONE, 0, 0);
    send(MODE_PUSH, 0, 0, 0, 0, 0);
    send(MODE_TRANSLATE, 32'sh7fffffff, 32'sh80000000, 32'sh00010000, 0, 0);
    send(MODE_POINT, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 0, 0);
    send(MODE_SCALE, 32'sh80000000, 32'sh7fffffff, 0, 0, 0);
    send(MODE_POINT, 32'sh80000000, 32'sh80000000, 32'sh80000000, 0, 0);
    send(MODE_POP, 0, 0, 0, 0, 0);
    send(MODE_ROTATE, 0, 0, 0, 2'd0, 32'sh7fffffff);
    send(MODE_ROTATE, 0, 0, 0, 2'd1, 32'sh80000000);
    send(MODE_ROTATE, 0, 0, 0, 2'd2, ANG_PI);
    send(MODE_ROTATE, 0, 0, 0, 2'd2, -ANG_HALF_PI - 1);
    send(MODE_ROTATE, 0, 0, 0, AXIS_BAD, Q_ONE);
    send(3'd6, 32'hffffffff, 32'hffffffff, 32'hffffffff, 2'd3, 32'hffffffff);
    send(3'd7, 0, 0, 0, 0, 0);
    send(MODE_POINT, Q_ONE, Q_ONE, Q_ONE, 0, 0);
    // Fill the stack to overflow and report the full level.
    for (int i = 0; i < STACK_DEPTH; i++) send(MODE_PUSH, 0, 0, 0, 0, 0);
    send(MODE_POINT, Q_ONE, 2 * Q_ONE, 3 * Q_ONE, 0, 0);
    for (int i = 0; i < STACK_DEPTH - 1; i++) send(MODE_POP, 0, 0, 0, 0, 0);

    for (int n = 0; n < 470; n++) begin
      send_random(checker_i.top_lvl);
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
